@@ rtl/ftm_pkg.sv @@
// ---------------------------------------------------------------------------
// ftm_pkg
// Shared types and constants of the flow throughput block: field widths,
// divider geometry, figure slots and register indexes.
// ---------------------------------------------------------------------------
package ftm_pkg;

    // field widths
    localparam int BYTE_W   = 48;
    localparam int SEQ_W    = 32;
    localparam int DUR_W    = 40;
    localparam int RATE_W   = 32;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 1;

    // numerator is bytes * 8 * scale; a byte sum gains one bit
    localparam int SUM_W     = BYTE_W + 1;
    localparam int RES_SCALE = 1000;
    localparam int BIT_SCALE = 8 * RES_SCALE;
    localparam int NUM_W     = SUM_W + $clog2(BIT_SCALE);

    // one divider cell per quotient bit
    localparam int NUM_STEPS = RATE_W;
    localparam int TOP_W     = NUM_W - NUM_STEPS;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RATE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RATE = 1'd1;

    // figure carried by a divider beat
    typedef enum logic [1:0] {
        SLOT_SESSION = 2'd0,
        SLOT_PAYLOAD = 2'd1,
        SLOT_TO_UE   = 2'd2,
        SLOT_TO_NET  = 2'd3
    } slot_t;

    // one beat in the divider chain
    typedef struct packed {
        logic              valid;
        slot_t             slot;
        logic              ovf;
        logic              zero;
        logic [DUR_W-1:0]  rem;
        logic [RATE_W-1:0] word;
        logic [DUR_W-1:0]  dur;
    } cell_t;

endpackage

@@ rtl/ftm_counters_if.sv @@
// ---------------------------------------------------------------------------
// ftm_counters_if
// Channel carrying one flow's per-period counters.
// ---------------------------------------------------------------------------
interface ftm_counters_if;
    import ftm_pkg::*;

    logic             valid;
    logic             ready;
    logic [BYTE_W-1:0] bytes_ue_to_net;
    logic [BYTE_W-1:0] bytes_net_to_ue;
    logic [BYTE_W-1:0] unique_bytes_to_ue;
    logic [BYTE_W-1:0] unique_bytes_to_net;
    logic [SEQ_W-1:0]  expected_seq_to_ue;
    logic [SEQ_W-1:0]  expected_seq_to_net;
    logic [SEQ_W-1:0]  ack_to_ue;
    logic [SEQ_W-1:0]  ack_to_net;
    logic [DUR_W-1:0]  duration_all;
    logic [DUR_W-1:0]  duration_to_ue;
    logic [DUR_W-1:0]  duration_to_net;

    modport source (
        output valid, bytes_ue_to_net, bytes_net_to_ue, unique_bytes_to_ue,
               unique_bytes_to_net, expected_seq_to_ue, expected_seq_to_net,
               ack_to_ue, ack_to_net, duration_all, duration_to_ue, duration_to_net,
        input  ready
    );

    modport sink (
        input  valid, bytes_ue_to_net, bytes_net_to_ue, unique_bytes_to_ue,
               unique_bytes_to_net, expected_seq_to_ue, expected_seq_to_net,
               ack_to_ue, ack_to_net, duration_all, duration_to_ue, duration_to_net,
        output ready
    );

endinterface

@@ rtl/ftm_rates_if.sv @@
// ---------------------------------------------------------------------------
// ftm_rates_if
// Channel carrying the four clamped throughput figures.
// ---------------------------------------------------------------------------
interface ftm_rates_if;
    import ftm_pkg::*;

    logic              valid;
    logic              ready;
    logic [RATE_W-1:0] session_rate;
    logic [RATE_W-1:0] payload_rate;
    logic [RATE_W-1:0] payload_rate_to_ue;
    logic [RATE_W-1:0] payload_rate_to_net;

    modport source (
        output valid, session_rate, payload_rate, payload_rate_to_ue,
               payload_rate_to_net,
        input  ready
    );

    modport sink (
        input  valid, session_rate, payload_rate, payload_rate_to_ue,
               payload_rate_to_net,
        output ready
    );

endinterface

@@ rtl/flow_throughput_metrics.sv @@
// ---------------------------------------------------------------------------
// flow_throughput_metrics
// Four clamped throughput figures per flow from period counters, using one
// chain of restoring division cells shared by the four quotients.
//
//   channel   dir  carries
//   counters  in   byte counts, sequence/ack numbers, durations
//   rates     out  session, payload, payload to ue, payload to net
//   wr_*      in   register writes (0 min rate, 1 max rate)
//
// An item issues one quotient per cycle while the chain is not held, so a
// new item is taken once its four quotients have issued; the single divider
// chain sets this. An accepted item passes 4 issue slots, 32 division cells
// and the output register.
// Reset clears valid state and sets min 0, max all ones.
// A stalled result holds the whole chain and the front end only when the
// next finished item reaches its end.
// ---------------------------------------------------------------------------
module flow_throughput_metrics (
    input  logic                           clk,
    input  logic                           rst_n,
    ftm_counters_if.sink                   counters,
    ftm_rates_if.source                    rates,
    input  logic                           wr_en,
    input  logic [ftm_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [ftm_pkg::CFG_W-1:0]      wr_data
);
    import ftm_pkg::*;

    cell_t             stage [0:NUM_STEPS];
    cell_t             tail;
    logic              adv;
    logic              tail_last;
    logic [RATE_W-1:0] min_reg;
    logic [RATE_W-1:0] max_reg;
    logic [RATE_W-1:0] clamped;
    logic [RATE_W-1:0] r_session_reg;
    logic [RATE_W-1:0] r_payload_reg;
    logic [RATE_W-1:0] r_to_ue_reg;
    logic              out_valid_reg;
    logic [RATE_W-1:0] o_session_reg;
    logic [RATE_W-1:0] o_payload_reg;
    logic [RATE_W-1:0] o_to_ue_reg;
    logic [RATE_W-1:0] o_to_net_reg;

    assign tail      = stage[NUM_STEPS];
    assign tail_last = tail.valid && tail.slot == SLOT_TO_NET;
    assign adv       = !(tail_last && out_valid_reg && !rates.ready);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= '0;
            max_reg <= '1;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_MIN_RATE: min_reg <= wr_data;
                REG_MAX_RATE: max_reg <= wr_data;
                default:      ;
            endcase
        end
    end

    // front end and division chain
    ftm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .counters (counters),
        .issue    (stage[0])
    );

    for (genvar i = 0; i < NUM_STEPS; i++)
    begin : g_cell
        ftm_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .adv   (adv),
            .d     (stage[i]),
            .q     (stage[i+1])
        );
    end

    // clamp at chain end
    always_comb
    begin
        if (tail.zero)
        begin
            clamped = min_reg;
        end
        else if (tail.ovf || tail.word > max_reg)
        begin
            clamped = max_reg;
        end
        else if (tail.word < min_reg)
        begin
            clamped = min_reg;
        end
        else
        begin
            clamped = tail.word;
        end
    end

    // collect figures
    always_ff @(posedge clk)
    begin
        if (adv && tail.valid)
        begin
            case (tail.slot)
                SLOT_SESSION: r_session_reg <= clamped;
                SLOT_PAYLOAD: r_payload_reg <= clamped;
                SLOT_TO_UE:   r_to_ue_reg   <= clamped;
                default:      ;
            endcase
        end
        if (adv && tail_last)
        begin
            o_session_reg <= r_session_reg;
            o_payload_reg <= r_payload_reg;
            o_to_ue_reg   <= r_to_ue_reg;
            o_to_net_reg  <= clamped;
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv && tail_last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rates.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign rates.valid               = out_valid_reg;
    assign rates.session_rate        = o_session_reg;
    assign rates.payload_rate        = o_payload_reg;
    assign rates.payload_rate_to_ue  = o_to_ue_reg;
    assign rates.payload_rate_to_net = o_to_net_reg;

`ifndef SYNTHESIS
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |-> tail_last && out_valid_reg)
        else $error("chain held without a finished item waiting");
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        rates.valid && rates.ready && !(adv && tail_last) |=> !rates.valid)
        else $error("result shown twice");
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        adv && tail_last |-> $past(tail.slot) == SLOT_TO_UE || !$past(adv))
        else $error("last figure out of slot order");
`endif

endmodule

@@ rtl/ftm_cell.sv @@
// ---------------------------------------------------------------------------
// ftm_cell
// One restoring division step: shifts the next numerator bit into the
// partial remainder and the quotient bit into the word.
// ---------------------------------------------------------------------------
module ftm_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  ftm_pkg::cell_t d,
    output ftm_pkg::cell_t q
);
    import ftm_pkg::*;

    cell_t              q_reg;
    cell_t              q_next;
    logic [DUR_W:0]     trial;
    logic               ge;

    // trial subtract
    always_comb
    begin
        trial  = {d.rem, d.word[RATE_W-1]};
        ge     = (trial >= {1'b0, d.dur});
        q_next = d;
        q_next.rem  = ge ? DUR_W'(trial - {1'b0, d.dur}) : trial[DUR_W-1:0];
        q_next.word = {d.word[RATE_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else if (adv)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

@@ rtl/ftm_front.sv @@
// ---------------------------------------------------------------------------
// ftm_front
// Takes a counters beat, works out the acknowledged byte counts, and issues
// the four numerator/duration pairs one per cycle while the chain advances.
// ---------------------------------------------------------------------------
module ftm_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    ftm_counters_if.sink   counters,
    output ftm_pkg::cell_t issue
);
    import ftm_pkg::*;

    logic              hold_valid_reg;
    logic              hold_valid_next;
    slot_t             slot_reg;
    slot_t             slot_next;
    logic [SUM_W-1:0]  b_sum_reg;
    logic [SUM_W-1:0]  k_sum_reg;
    logic [BYTE_W-1:0] k_ue_reg;
    logic [BYTE_W-1:0] k_net_reg;
    logic [DUR_W-1:0]  d_all_reg;
    logic [DUR_W-1:0]  d_ue_reg;
    logic [DUR_W-1:0]  d_net_reg;
    cell_t             issue_reg;
    cell_t             issue_next;
    logic              accept;
    logic              fire;
    logic [BYTE_W-1:0] k_ue;
    logic [BYTE_W-1:0] k_net;
    logic [SUM_W-1:0]  sel_bytes;
    logic [DUR_W-1:0]  sel_dur;
    logic [NUM_W-1:0]  num;

    // unique bytes less the unacknowledged span
    function automatic logic [BYTE_W-1:0] acked_bytes(
        input logic [BYTE_W-1:0] uniq,
        input logic [SEQ_W-1:0]  expected,
        input logic [SEQ_W-1:0]  ack
    );
        logic [SEQ_W-1:0] unacked;
        unacked = '0;
        if (expected > ack && expected != '0 && ack != '0)
        begin
            unacked = expected - ack;
        end
        return (uniq > BYTE_W'(unacked)) ? (uniq - BYTE_W'(unacked)) : '0;
    endfunction

    assign fire            = hold_valid_reg && adv;
    assign counters.ready  = !hold_valid_reg || (fire && slot_reg == SLOT_TO_NET);
    assign accept          = counters.valid && counters.ready;
    assign k_ue  = acked_bytes(counters.unique_bytes_to_ue, counters.expected_seq_to_ue,
                               counters.ack_to_ue);
    assign k_net = acked_bytes(counters.unique_bytes_to_net, counters.expected_seq_to_net,
                               counters.ack_to_net);

    // hold register and slot counter
    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        slot_next       = slot_reg;
        if (fire)
        begin
            slot_next = slot_t'(slot_reg + 2'd1);
            if (slot_reg == SLOT_TO_NET)
            begin
                hold_valid_next = 1'b0;
            end
        end
        if (accept)
        begin
            hold_valid_next = 1'b1;
            slot_next       = SLOT_SESSION;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            slot_reg       <= SLOT_SESSION;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            slot_reg       <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_sum_reg <= SUM_W'(counters.bytes_ue_to_net) + SUM_W'(counters.bytes_net_to_ue);
            k_sum_reg <= SUM_W'(k_ue) + SUM_W'(k_net);
            k_ue_reg  <= k_ue;
            k_net_reg <= k_net;
            d_all_reg <= counters.duration_all;
            d_ue_reg  <= counters.duration_to_ue;
            d_net_reg <= counters.duration_to_net;
        end
    end

    // operand select and scaling for the current slot
    always_comb
    begin
        case (slot_reg)
            SLOT_SESSION:
            begin
                sel_bytes = b_sum_reg;
                sel_dur   = d_all_reg;
            end
            SLOT_PAYLOAD:
            begin
                sel_bytes = k_sum_reg;
                sel_dur   = d_all_reg;
            end
            SLOT_TO_UE:
            begin
                sel_bytes = SUM_W'(k_ue_reg);
                sel_dur   = d_ue_reg;
            end
            SLOT_TO_NET:
            begin
                sel_bytes = SUM_W'(k_net_reg);
                sel_dur   = d_net_reg;
            end
            default:
            begin
                sel_bytes = '0;
                sel_dur   = '0;
            end
        endcase
        num = NUM_W'(sel_bytes) * NUM_W'(BIT_SCALE);
        issue_next.valid = hold_valid_reg;
        issue_next.slot  = slot_reg;
        issue_next.zero  = (sel_dur == '0);
        issue_next.ovf   = (DUR_W'(num[NUM_W-1:NUM_STEPS]) >= sel_dur);
        issue_next.rem   = DUR_W'(num[NUM_W-1:NUM_STEPS]);
        issue_next.word  = num[NUM_STEPS-1:0];
        issue_next.dur   = sel_dur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg <= '0;
        end
        else if (adv)
        begin
            issue_reg <= issue_next;
        end
    end

    assign issue = issue_reg;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> hold_valid_reg && slot_reg == SLOT_SESSION)
        else $error("accepted beat not held at first slot");
    a_no_accept_midway: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg && slot_reg != SLOT_TO_NET |-> !counters.ready)
        else $error("ready raised before last slot issued");
    a_issue_order: assert property (@(posedge clk) disable iff (!rst_n)
        fire && slot_reg != SLOT_TO_NET |=> hold_valid_reg)
        else $error("hold dropped before all slots issued");
`endif

endmodule

@@ tb/sv/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for flow_throughput_metrics. A scoreboard class works
// out the four clamped throughput figures of every accepted counters beat
// and compares them, field by field and in order, with the rates beats.
// The run goes through several clamp settings and idling phases.
// ---------------------------------------------------------------------------
module testbench;
    import ftm_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 60;
    localparam int PER_PHASE   = 325;
    localparam int NUM_PHASES  = 6;

    typedef struct {
        logic [BYTE_W-1:0] up;
        logic [BYTE_W-1:0] dn;
        logic [BYTE_W-1:0] uniq_ue;
        logic [BYTE_W-1:0] uniq_net;
        logic [SEQ_W-1:0]  exp_ue;
        logic [SEQ_W-1:0]  exp_net;
        logic [SEQ_W-1:0]  ack_ue;
        logic [SEQ_W-1:0]  ack_net;
        logic [DUR_W-1:0]  dur_all;
        logic [DUR_W-1:0]  dur_ue;
        logic [DUR_W-1:0]  dur_net;
    } flow_counts_t;

    typedef struct {
        logic [RATE_W-1:0] session;
        logic [RATE_W-1:0] payload;
        logic [RATE_W-1:0] to_ue;
        logic [RATE_W-1:0] to_net;
    } flow_rates_t;

    // throughput predictor and store of expected figures
    class rate_scoreboard;
        logic [RATE_W-1:0] min_rate;
        logic [RATE_W-1:0] max_rate;
        flow_rates_t       rates_due[$];
        int                errors;

        function void reset_regs();
            min_rate = '0;
            max_rate = '1;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == REG_MIN_RATE)
                min_rate = val;
            else if (idx == REG_MAX_RATE)
                max_rate = val;
        endfunction

        function logic [BYTE_W:0] acked(logic [BYTE_W-1:0] uniq, logic [SEQ_W-1:0] expd,
                                        logic [SEQ_W-1:0] ack);
            logic [BYTE_W-1:0] unacked;
            unacked = '0;
            if (expd > ack && expd != 0 && ack != 0)
                unacked = BYTE_W'(expd - ack);
            return (BYTE_W+1)'((uniq > unacked) ? uniq - unacked : '0);
        endfunction

        function logic [RATE_W-1:0] clamped_rate(logic [BYTE_W:0] bytes, logic [DUR_W-1:0] dur);
            logic [63:0] q;
            if (dur == 0)
                return min_rate;
            q = (64'(bytes) * 64'(BIT_SCALE)) / 64'(dur);
            if (q > 64'(max_rate))
                return max_rate;
            if (q < 64'(min_rate))
                return min_rate;
            return q[RATE_W-1:0];
        endfunction

        function void note_counts(flow_counts_t c);
            logic [BYTE_W:0] k_ue;
            logic [BYTE_W:0] k_net;
            flow_rates_t     r;
            k_ue      = acked(c.uniq_ue, c.exp_ue, c.ack_ue);
            k_net     = acked(c.uniq_net, c.exp_net, c.ack_net);
            r.session = clamped_rate(49'(c.up) + 49'(c.dn), c.dur_all);
            r.payload = clamped_rate(k_ue + k_net, c.dur_all);
            r.to_ue   = clamped_rate(k_ue, c.dur_ue);
            r.to_net  = clamped_rate(k_net, c.dur_net);
            rates_due = {rates_due, r};
        endfunction

        function void check_rates(flow_rates_t got);
            flow_rates_t want;
            if (rates_due.size() == 0)
            begin
                $display("%0t: unexpected rates beat %h %h %h %h", $time,
                         got.session, got.payload, got.to_ue, got.to_net);
                errors++;
                return;
            end
            want = rates_due.pop_front();
            if (got.session !== want.session)
            begin
                $display("%0t: session_rate expected %h actual %h", $time, want.session,
                         got.session);
                errors++;
            end
            if (got.payload !== want.payload)
            begin
                $display("%0t: payload_rate expected %h actual %h", $time, want.payload,
                         got.payload);
                errors++;
            end
            if (got.to_ue !== want.to_ue)
            begin
                $display("%0t: payload_rate_to_ue expected %h actual %h", $time, want.to_ue,
                         got.to_ue);
                errors++;
            end
            if (got.to_net !== want.to_net)
            begin
                $display("%0t: payload_rate_to_net expected %h actual %h", $time, want.to_net,
                         got.to_net);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [CFG_W-1:0]     wr_data;
    int                   send_idle_pct;
    int                   stall_pct;
    int                   hold_requests;
    int                   hold_served;
    int                   hold_left;
    int                   cycles;
    rate_scoreboard       sb;

    ftm_counters_if counters ();
    ftm_rates_if    rates ();

    flow_throughput_metrics dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .counters (counters.sink),
        .rates    (rates.source),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // receiver: random stalls plus long hold-offs on request
    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            hold_left   <= 400;
            rates.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left   <= hold_left - 1;
            rates.ready <= 1'b0;
        end
        else
            rates.ready <= ($urandom_range(99) >= stall_pct);
    end

    // watch both channels
    always @(posedge clk)
    begin
        flow_counts_t c;
        flow_rates_t  r;
        if (rst_n && counters.valid && counters.ready)
        begin
            c.up       = counters.bytes_ue_to_net;
            c.dn       = counters.bytes_net_to_ue;
            c.uniq_ue  = counters.unique_bytes_to_ue;
            c.uniq_net = counters.unique_bytes_to_net;
            c.exp_ue   = counters.expected_seq_to_ue;
            c.exp_net  = counters.expected_seq_to_net;
            c.ack_ue   = counters.ack_to_ue;
            c.ack_net  = counters.ack_to_net;
            c.dur_all  = counters.duration_all;
            c.dur_ue   = counters.duration_to_ue;
            c.dur_net  = counters.duration_to_net;
            sb.note_counts(c);
        end
        if (rst_n && rates.valid && rates.ready)
        begin
            r.session = rates.session_rate;
            r.payload = rates.payload_rate;
            r.to_ue   = rates.payload_rate_to_ue;
            r.to_net  = rates.payload_rate_to_net;
            sb.check_rates(r);
        end
    end

    // timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    // random value of a field, biased toward zero, all ones and small values
    function automatic logic [63:0] field_value(int width);
        logic [63:0] full;
        logic [63:0] mask;
        int          pick;
        full = {$urandom, $urandom};
        mask = (64'd1 << width) - 1;
        pick = $urandom_range(99);
        if (pick < 10)
            return '0;
        if (pick < 20)
            return mask;
        if (pick < 55)
            return full & mask;
        return full & ((64'd1 << $urandom_range(width, 1)) - 1);
    endfunction

    function automatic flow_counts_t random_counts();
        flow_counts_t c;
        c.up       = BYTE_W'(field_value(BYTE_W));
        c.dn       = BYTE_W'(field_value(BYTE_W));
        c.uniq_ue  = BYTE_W'(field_value(BYTE_W));
        c.uniq_net = BYTE_W'(field_value(BYTE_W));
        c.exp_ue   = SEQ_W'(field_value(SEQ_W));
        c.exp_net  = SEQ_W'(field_value(SEQ_W));
        c.ack_ue   = SEQ_W'(field_value(SEQ_W));
        c.ack_net  = SEQ_W'(field_value(SEQ_W));
        c.dur_all  = DUR_W'(field_value(DUR_W));
        c.dur_ue   = DUR_W'(field_value(DUR_W));
        c.dur_net  = DUR_W'(field_value(DUR_W));
        // half of the flows have acks trailing the sequence by a small window
        if ($urandom_range(99) < 50)
        begin
            c.ack_ue  = c.exp_ue - $urandom_range(70000);
            c.ack_net = c.exp_net - $urandom_range(70000);
        end
        return c;
    endfunction

    task automatic send_counts(flow_counts_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            counters.valid <= 1'b0;
            @(posedge clk);
        end
        counters.valid               <= 1'b1;
        counters.bytes_ue_to_net     <= c.up;
        counters.bytes_net_to_ue     <= c.dn;
        counters.unique_bytes_to_ue  <= c.uniq_ue;
        counters.unique_bytes_to_net <= c.uniq_net;
        counters.expected_seq_to_ue  <= c.exp_ue;
        counters.expected_seq_to_net <= c.exp_net;
        counters.ack_to_ue           <= c.ack_ue;
        counters.ack_to_net          <= c.ack_net;
        counters.duration_all        <= c.dur_all;
        counters.duration_to_ue      <= c.dur_ue;
        counters.duration_to_net     <= c.dur_net;
        @(posedge clk);
        while (!counters.ready)
            @(posedge clk);
    endtask

    // sender pause until every expected figure has come back
    task automatic drain();
        counters.valid <= 1'b0;
        @(posedge clk);
        while (sb.rates_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(posedge clk);
        wr_en <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic send_directed(logic [BYTE_W-1:0] bytes, logic [SEQ_W-1:0] expd,
                                 logic [SEQ_W-1:0] ack, logic [DUR_W-1:0] dur);
        flow_counts_t c;
        c.up       = bytes;
        c.dn       = bytes;
        c.uniq_ue  = bytes;
        c.uniq_net = ~bytes;
        c.exp_ue   = expd;
        c.exp_net  = ack;
        c.ack_ue   = ack;
        c.ack_net  = expd;
        c.dur_all  = dur;
        c.dur_ue   = dur;
        c.dur_net  = ~dur;
        send_counts(c);
    endtask

    // stimulus
    initial
    begin
        logic [CFG_W-1:0] min_set [NUM_PHASES];
        logic [CFG_W-1:0] max_set [NUM_PHASES];
        int               idle_set [NUM_PHASES];
        int               stall_set [NUM_PHASES];
        min_set   = '{32'd0, 32'hFFFF_FFFF, 32'd1000, 32'd0, 32'd123456, 32'hFFFF_FFFF};
        max_set   = '{32'hFFFF_FFFF, 32'd0, 32'd50_000_000, 32'd0, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF};
        idle_set  = '{0, 76, 0, 28, 0, 76};
        stall_set = '{0, 0, 76, 28, 0, 0};
        sb = new();
        sb.reset_regs();
        sb.errors      = 0;
        rst_n          = 1'b0;
        cycles         = 0;
        hold_requests  = 0;
        hold_served    = 0;
        hold_left      = 0;
        send_idle_pct  = 0;
        stall_pct      = 0;
        wr_en          = 1'b0;
        wr_index       = '0;
        wr_data        = '0;
        rates.ready    = 1'b0;
        counters.valid = 1'b0;
        counters.bytes_ue_to_net     = '0;
        counters.bytes_net_to_ue     = '0;
        counters.unique_bytes_to_ue  = '0;
        counters.unique_bytes_to_net = '0;
        counters.expected_seq_to_ue  = '0;
        counters.expected_seq_to_net = '0;
        counters.ack_to_ue           = '0;
        counters.ack_to_net          = '0;
        counters.duration_all        = '0;
        counters.duration_to_ue      = '0;
        counters.duration_to_net     = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset clamps, extremes, zero durations, ack corner cases
        send_directed('0, '0, '0, '0);
        send_directed('1, '1, '1, '1);
        send_directed('1, 32'd5000, 32'd1000, 40'd1);
        send_directed(48'd100, 32'd5000, 32'd1000, 40'd8000);
        send_directed(48'd100, 32'd5000, 32'd0, 40'd3);
        send_directed(48'd100, 32'd0, 32'd7, 40'd1000);
        send_directed(48'd4000, 32'd9000, 32'd9000, 40'd0);
        send_directed(48'd4000, 32'd9001, 32'd9000, 40'd7);
        send_directed(48'd3999, 32'h8000_0000, 32'd1, 40'h80_0000_0000);
        send_directed(48'h8000_0000_0000, 32'hFFFF_FFFF, 32'd1, 40'd1);
        send_directed(48'd537, 32'd12, 32'd11, 40'd1);
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_reg(REG_MIN_RATE, min_set[p]);
            write_reg(REG_MAX_RATE, max_set[p]);
            send_idle_pct = idle_set[p];
            stall_pct     = stall_set[p];
            if (p == 4)
                hold_requests = hold_requests + 1;
            if (p == 1)
                send_directed(48'd537, 32'd12, 32'd11, 40'd0);
            for (int i = 0; i < PER_PHASE; i++)
                send_counts(random_counts());
            drain();
        end

        if (sb.errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
